// File: sv/mbde_pkg.sv
// ----------------------------------------------------------------------------
// mbde_pkg
// Shared types and constants for the multi-button debounce event block.
// ----------------------------------------------------------------------------
package mbde_pkg;

	localparam int unsigned OUT_W   = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned DEB_W   = 16;
	localparam int unsigned TSEL_W  = 3;
	localparam int unsigned TOUT_W  = 19;
	localparam int unsigned OP_W    = 2;
	localparam int unsigned CIDX_W  = 1;
	localparam int unsigned CDATA_W = 16;

	localparam logic [OP_W-1:0] OP_SCAN      = 2'd0;
	localparam logic [OP_W-1:0] OP_WAKE      = 2'd1;
	localparam logic [OP_W-1:0] OP_ACT_RESET = 2'd2;

	localparam logic [CIDX_W-1:0] REG_DEBOUNCE = 1'b0;
	localparam logic [CIDX_W-1:0] REG_TIMEOUT  = 1'b1;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd50;
	localparam logic [TSEL_W-1:0] TSEL_MAX       = 3'd4;

	// per-cell status towards the top level
	typedef struct packed {
		logic level;
		logic prior;
		logic event_bit;
		logic press_taken;
	} cell_stat_t;

	function automatic logic [TOUT_W-1:0] timeout_lookup(input logic [TSEL_W-1:0] sel);
		logic [TOUT_W-1:0] val;
		unique case (sel)
			3'd1:    val = 19'd30000;
			3'd2:    val = 19'd60000;
			3'd3:    val = 19'd120000;
			3'd4:    val = 19'd300000;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

// File: sv/mbde_ifs.sv
// ----------------------------------------------------------------------------
// mbde channel interfaces
// Valid/ready channels for scan items and result items.
// ----------------------------------------------------------------------------
interface mbde_scan_if;
	logic                          valid;
	logic                          ready;
	logic [mbde_pkg::OP_W-1:0]     opcode;
	logic [mbde_pkg::TIME_W-1:0]   now_ms;
	logic [mbde_pkg::OUT_W-1:0]    raw_pressed;

	modport source (output valid, opcode, now_ms, raw_pressed, input ready);
	modport sink   (input valid, opcode, now_ms, raw_pressed, output ready);
endinterface

interface mbde_result_if;
	logic                          valid;
	logic                          ready;
	logic [mbde_pkg::OUT_W-1:0]    stable_pressed;
	logic [mbde_pkg::OUT_W-1:0]    press_edges;
	logic [mbde_pkg::OUT_W-1:0]    release_edges;
	logic [mbde_pkg::OUT_W-1:0]    event_mask;
	logic [mbde_pkg::TIME_W-1:0]   activity_time;
	logic [mbde_pkg::TOUT_W-1:0]   timeout_ms;
	logic                          skip_pending;

	modport source (output valid, stable_pressed, press_edges, release_edges, event_mask,
		activity_time, timeout_ms, skip_pending, input ready);
	modport sink   (input valid, stable_pressed, press_edges, release_edges, event_mask,
		activity_time, timeout_ms, skip_pending, output ready);
endinterface

// File: sv/multi_button_debounce_events_top.sv
// Output: each accepted item's result is registered; the scan ripples through the
// row of button cells combinationally. Throughput: one item per cycle; the output
// register frees up as the result is taken and stalls the scan until it is.
// Reset: asynchronous, active low; levels, stamps, activity time and suppress flag
// clear to zero, debounce time to 50 ms, timeout selector to off.
// ----------------------------------------------------------------------------
// multi_button_debounce_events_top
// Timestamp-lockout debouncer for a row of buttons with wake suppression.
// ----------------------------------------------------------------------------
module multi_button_debounce_events_top #(
	parameter int unsigned BUTTON_COUNT = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [mbde_pkg::CIDX_W-1:0]       cfg_index,
	input  logic [mbde_pkg::CDATA_W-1:0]      cfg_wdata,
	mbde_scan_if.sink                         scan,
	mbde_result_if.source                     result
);

	logic [mbde_pkg::DEB_W-1:0]    debounce_q;
	logic [mbde_pkg::TSEL_W-1:0]   tsel_q;
	logic [mbde_pkg::TIME_W-1:0]   activity_q;
	logic                          suppress_q;

	logic                          out_valid_q;
	logic [mbde_pkg::OUT_W-1:0]    stable_q;
	logic [mbde_pkg::OUT_W-1:0]    press_q;
	logic [mbde_pkg::OUT_W-1:0]    release_q;
	logic [mbde_pkg::OUT_W-1:0]    event_q;

	logic                          accept;
	logic                          scan_en;
	logic [BUTTON_COUNT:0]         sup_chain;
	mbde_pkg::cell_stat_t          stat [BUTTON_COUNT];
	logic [BUTTON_COUNT-1:0]       press_taken;
	logic [mbde_pkg::OUT_W-1:0]    lvl_n;
	logic [mbde_pkg::OUT_W-1:0]    prior_n;
	logic [mbde_pkg::OUT_W-1:0]    event_n;
	logic [mbde_pkg::TSEL_W-1:0]   cfg_tsel;

	assign scan.ready = !out_valid_q || result.ready;
	assign accept     = scan.valid && scan.ready;
	assign scan_en    = accept && (scan.opcode == mbde_pkg::OP_SCAN);

	// configuration
	assign cfg_tsel = cfg_wdata[mbde_pkg::TSEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= mbde_pkg::DEBOUNCE_RESET;
			tsel_q     <= '0;
		end else if (cfg_wen) begin
			if (cfg_index == mbde_pkg::REG_DEBOUNCE) begin
				debounce_q <= cfg_wdata[mbde_pkg::DEB_W-1:0];
			end else if (cfg_index == mbde_pkg::REG_TIMEOUT && cfg_tsel <= mbde_pkg::TSEL_MAX) begin
				tsel_q <= cfg_tsel;
			end
		end
	end

	// row of button cells
	assign sup_chain[0] = suppress_q;

	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_cell
		logic reading;
		if (i < mbde_pkg::OUT_W) begin : g_raw
			assign reading = scan.raw_pressed[i];
		end else begin : g_none
			assign reading = 1'b0;
		end

		mbde_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.scan_en       (scan_en),
			.reading       (reading),
			.now_ms        (scan.now_ms),
			.debounce_time (debounce_q),
			.sup_in        (sup_chain[i]),
			.sup_out       (sup_chain[i+1]),
			.stat          (stat[i])
		);

		assign press_taken[i] = stat[i].press_taken;
	end

	for (genvar j = 0; j < mbde_pkg::OUT_W; j++) begin : g_map
		if (j < BUTTON_COUNT) begin : g_btn
			assign lvl_n[j]   = stat[j].level;
			assign prior_n[j] = stat[j].prior;
			assign event_n[j] = stat[j].event_bit;
		end else begin : g_pad
			assign lvl_n[j]   = 1'b0;
			assign prior_n[j] = 1'b0;
			assign event_n[j] = 1'b0;
		end
	end

	// activity time and suppress flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activity_q <= '0;
			suppress_q <= 1'b0;
		end else if (accept) begin
			priority if (scan.opcode == mbde_pkg::OP_WAKE) begin
				activity_q <= scan.now_ms;
				suppress_q <= 1'b1;
			end else if (scan.opcode == mbde_pkg::OP_ACT_RESET) begin
				activity_q <= scan.now_ms;
			end else if (scan.opcode == mbde_pkg::OP_SCAN) begin
				if (|press_taken) begin
					activity_q <= scan.now_ms;
				end
				suppress_q <= sup_chain[BUTTON_COUNT];
			end else begin
				activity_q <= activity_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			stable_q  <= lvl_n;
			press_q   <= lvl_n & ~prior_n;
			release_q <= prior_n & ~lvl_n;
			event_q   <= scan_en ? event_n : '0;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.stable_pressed = stable_q;
	assign result.press_edges    = press_q;
	assign result.release_edges  = release_q;
	assign result.event_mask     = event_q;
	assign result.activity_time  = activity_q;
	assign result.timeout_ms     = mbde_pkg::timeout_lookup(tsel_q);
	assign result.skip_pending   = suppress_q;

	// checks
	a_event_on_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((event_q & ~(press_q | release_q)) == '0))
		else $error("event without an edge");

	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((press_q & release_q) == '0))
		else $error("press and release on one button");

	a_suppress_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(suppress_q) |-> $past(accept && scan.opcode == mbde_pkg::OP_WAKE))
		else $error("suppress set without wake item");

	a_activity_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(activity_q))
		else $error("activity time moved without an item");

endmodule

// File: sv/mbde_cell.sv
// ----------------------------------------------------------------------------
// mbde_cell
// One button: debounced level, prior level, change stamp and suppress ripple.
// ----------------------------------------------------------------------------
module mbde_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              scan_en,
	input  logic                              reading,
	input  logic [mbde_pkg::TIME_W-1:0]       now_ms,
	input  logic [mbde_pkg::DEB_W-1:0]        debounce_time,
	input  logic                              sup_in,
	output logic                              sup_out,
	output mbde_pkg::cell_stat_t              stat
);

	logic                          level_q;
	logic                          prior_q;
	logic [mbde_pkg::TIME_W-1:0]   stamp_q;
	logic [mbde_pkg::TIME_W-1:0]   elapsed;
	logic                          ripe;
	logic                          change;

	assign elapsed = now_ms - stamp_q;
	assign ripe    = elapsed > {{(mbde_pkg::TIME_W-mbde_pkg::DEB_W){1'b0}}, debounce_time};
	assign change  = scan_en && (reading != level_q) && ripe;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			prior_q <= 1'b0;
			stamp_q <= '0;
		end else begin
			if (scan_en) begin
				prior_q <= level_q;
			end
			if (change) begin
				level_q <= reading;
				stamp_q <= now_ms;
			end
		end
	end

	// a suppressed release clears the flag for the later cells
	assign sup_out = (change && sup_in && !reading) ? 1'b0 : sup_in;

	always_comb begin
		stat.level       = change ? reading : level_q;
		stat.prior       = scan_en ? level_q : prior_q;
		stat.event_bit   = change && !sup_in;
		stat.press_taken = change && reading;
	end

endmodule
